[rtl/core/cpa_pkg.sv]
// Shared constants and types for the contiguous page allocator.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package cpa_pkg;

    // Map geometry. PAGE_BYTES must be a power of two.
    localparam int PAGES      = 64;
    localparam int PAGE_BYTES = 1024;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // A run of MAX_RUN pages or more is refused outright.
    localparam int MAX_RUN    = 'h100;

    localparam int BYTES_W    = 20;
    localparam int IDX_W      = 6;
    localparam int LEN_W      = 8;
    localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CNT_W      = PAGE_W + 1;
    localparam int NEED_W     = BYTES_W + 1;
    localparam int SP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int SUM_W      = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Sequencer to page map: one write, clear or read address per cycle.
    typedef struct packed {
        logic              wr;
        logic              clr;
        logic [PAGE_W-1:0] addr;
        logic [LEN_W-1:0]  data;
    } t_map_cmd;

    // One result beat, before the output register.
    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] cnt;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/cpa_page_map.sv]
// Page map storage: entry memory plus a per-page in-use flag vector.
// Depends on cpa_pkg.
`default_nettype none

module cpa_page_map (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cpa_pkg::t_map_cmd             i_cmd,
    output logic     [cpa_pkg::PAGES-1:0]      o_used,
    output logic     [cpa_pkg::LEN_W-1:0]      o_rd_data
);
    import cpa_pkg::*;

    logic [LEN_W-1:0] r_mem [PAGES];
    logic [LEN_W-1:0] r_rd_data;
    logic [PAGES-1:0] r_used;
    logic             r_rd_used;

    // Entry memory; contents are only meaningful where the used flag is set.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_cmd.addr] <= i_cmd.data;
        end
        r_rd_data <= r_mem[i_cmd.addr];
    end

    // Flags act as valid bits: reset marks every page free at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_used <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_used[i_cmd.addr] <= 1'b1;
            end else if (i_cmd.clr) begin
                r_used[i_cmd.addr] <= 1'b0;
            end
            r_rd_used <= r_used[i_cmd.addr];
        end
    end

    assign o_used    = r_used;
    assign o_rd_data = r_rd_used ? r_rd_data : '0;

endmodule

`default_nettype wire

[rtl/core/cpa_ctrl.sv]
// Allocate/free sequencer: one pointer and run counter stepped over the map.
// Depends on cpa_pkg; drives cpa_page_map through a t_map_cmd.
`default_nettype none

module cpa_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_go,
    input  wire logic                          i_mode,
    input  wire logic [cpa_pkg::BYTES_W-1:0]   i_request_bytes,
    input  wire logic [cpa_pkg::IDX_W-1:0]     i_start_page,
    input  wire logic [cpa_pkg::PAGES-1:0]     i_used,
    input  wire logic [cpa_pkg::LEN_W-1:0]     i_rd_data,
    output cpa_pkg::t_map_cmd                  o_cmd,
    output cpa_pkg::t_result                   o_result,
    output logic                               o_busy
);
    import cpa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_MARK     = 6'b000100,
        S_FREE_RD  = 6'b001000,
        S_FREE_LEN = 6'b010000,
        S_FREE_CLR = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_ptr,   n_ptr;
    logic [CNT_W-1:0] r_first, n_first;
    logic [LEN_W-1:0] r_run,   n_run;
    logic [LEN_W-1:0] r_len,   n_len;
    logic [LEN_W-1:0] r_cnt,   n_cnt;

    logic [NEED_W-1:0] need;
    logic              need_bad;
    logic [SP_W-1:0]   sp_ext;
    logic [CNT_W-1:0]  rem;
    logic [LEN_W-1:0]  free_len;
    logic [15:0]       first_ext;
    logic              page_free;

    // Byte count rounded up to whole pages.
    assign need     = (NEED_W'(i_request_bytes) + NEED_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
    assign need_bad = (need == '0) || (need >= NEED_W'(MAX_RUN)) || (need > NEED_W'(PAGES));
    assign sp_ext   = SP_W'(i_start_page);

    // Pages left from the pointer to the end of the map; clamps a free.
    assign rem      = CNT_W'(PAGES) - r_ptr;
    assign free_len = (SUM_W'(i_rd_data) > SUM_W'(rem)) ? LEN_W'(rem) : i_rd_data;

    assign first_ext = 16'(r_first);
    assign page_free = !i_used[r_ptr[PAGE_W-1:0]];

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_first  = r_first;
        n_run    = r_run;
        n_len    = r_len;
        n_cnt    = r_cnt;
        o_cmd    = '{wr: 1'b0, clr: 1'b0, addr: r_ptr[PAGE_W-1:0], data: r_len};
        o_result = '{valid: 1'b0, ok: 1'b0, idx: '0, cnt: '0};

        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    if (i_mode == MODE_ALLOC) begin
                        if (need_bad) begin
                            o_result.valid = 1'b1;
                        end else begin
                            n_len   = need[LEN_W-1:0];
                            n_ptr   = '0;
                            n_first = '0;
                            n_run   = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (sp_ext >= SP_W'(PAGES)) begin
                            o_result.valid = 1'b1;
                        end else begin
                            n_ptr   = sp_ext[CNT_W-1:0];
                            n_state = S_FREE_RD;
                        end
                    end
                end
            end

            // First fit: r_first tracks where the current free run began.
            S_SCAN: begin
                if (r_ptr == CNT_W'(PAGES)) begin
                    o_result.valid = 1'b1;
                    n_state        = S_IDLE;
                end else if (page_free) begin
                    if (r_run + LEN_W'(1) == r_len) begin
                        n_ptr   = r_first;
                        n_cnt   = '0;
                        n_state = S_MARK;
                    end else begin
                        n_run = r_run + LEN_W'(1);
                        n_ptr = r_ptr + CNT_W'(1);
                    end
                end else begin
                    n_run   = '0;
                    n_first = r_ptr + CNT_W'(1);
                    n_ptr   = r_ptr + CNT_W'(1);
                end
            end

            // Head entry gets the run length, the rest get 1.
            S_MARK: begin
                o_cmd.wr   = 1'b1;
                o_cmd.data = (r_cnt == '0) ? r_len : LEN_W'(1);
                if (r_cnt == r_len - LEN_W'(1)) begin
                    o_result = '{valid: 1'b1, ok: 1'b1, idx: first_ext[IDX_W-1:0], cnt: r_len};
                    n_state  = S_IDLE;
                end else begin
                    n_cnt = r_cnt + LEN_W'(1);
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end

            // Map read of the head entry is in flight.
            S_FREE_RD: begin
                n_state = S_FREE_LEN;
            end

            S_FREE_LEN: begin
                if (free_len == '0) begin
                    o_result = '{valid: 1'b1, ok: 1'b1, idx: '0, cnt: '0};
                    n_state  = S_IDLE;
                end else begin
                    n_len   = free_len;
                    n_cnt   = '0;
                    n_state = S_FREE_CLR;
                end
            end

            S_FREE_CLR: begin
                o_cmd.clr = 1'b1;
                if (r_cnt == r_len - LEN_W'(1)) begin
                    o_result = '{valid: 1'b1, ok: 1'b1, idx: '0, cnt: r_len};
                    n_state  = S_IDLE;
                end else begin
                    n_cnt = r_cnt + LEN_W'(1);
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_first <= n_first;
        r_run   <= n_run;
        r_len   <= n_len;
        r_cnt   <= n_cnt;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

[rtl/core/contiguous_page_allocator.sv]
// Top level of the first-fit contiguous page allocator.
// Depends on cpa_pkg, cpa_page_map and cpa_ctrl.
//
//   channel   handshake             payload
//   request   start / busy          i_mode, i_request_bytes, i_start_page
//   result    o_valid (one cycle)   o_ok, o_page_index, o_page_count
//
// A beat is taken when start is high and busy is low; its result strobes
// exactly once, from the result register, in the cycle after the sequencer finishes.
// Allocate: S_SCAN seeks a free run page by page, else refuses; S_MARK writes it.
// Free: S_FREE_RD and S_FREE_LEN fetch the head entry; S_FREE_CLR clears pages.
// Bad sizes or out-of-range pages are answered from S_IDLE.
// The pointer steps one page a cycle, setting the rate; busy holds off start.
// Synchronous reset frees every page immediately; the result side never stalls.
`default_nettype none

module contiguous_page_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          i_mode,
    input  wire logic [cpa_pkg::BYTES_W-1:0]   i_request_bytes,
    input  wire logic [cpa_pkg::IDX_W-1:0]     i_start_page,
    output logic                               busy,
    output logic                               o_valid,
    output logic                               o_ok,
    output logic     [cpa_pkg::IDX_W-1:0]      o_page_index,
    output logic     [cpa_pkg::LEN_W-1:0]      o_page_count
);
    import cpa_pkg::*;

    t_map_cmd         map_cmd;
    t_result          result;
    logic [PAGES-1:0] used;
    logic [LEN_W-1:0] rd_data;
    logic             ctrl_busy;
    logic             go;

    logic             r_valid;
    logic             r_ok;
    logic [IDX_W-1:0] r_idx;
    logic [LEN_W-1:0] r_cnt;

    assign go = start && !ctrl_busy;

    cpa_page_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (map_cmd),
        .o_used    (used),
        .o_rd_data (rd_data)
    );

    cpa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (go),
        .i_mode          (i_mode),
        .i_request_bytes (i_request_bytes),
        .i_start_page    (i_start_page),
        .i_used          (used),
        .i_rd_data       (rd_data),
        .o_cmd           (map_cmd),
        .o_result        (result),
        .o_busy          (ctrl_busy)
    );

    // Result register: one strobe per request beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_ok  <= result.ok;
            r_idx <= result.idx;
            r_cnt <= result.cnt;
        end
    end

    assign busy         = ctrl_busy;
    assign o_valid      = r_valid;
    assign o_ok         = r_ok;
    assign o_page_index = r_idx;
    assign o_page_count = r_cnt;

endmodule

`default_nettype wire

[tb/contiguous_page_allocator_tb.sv]
// Self-checking testbench for contiguous_page_allocator: a directed table, then random
// allocate and free traffic, checked against a shadow page map kept in the bench.
// Depends on cpa_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module contiguous_page_allocator_tb;
    import cpa_pkg::*;

    localparam int N_DIR      = 24;
    localparam int N_RANDOM   = 1400;
    localparam int STALL_MAX  = 3000;
    localparam int SETTLE     = 2 * PAGES + 20;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] cnt;
    } t_grant;

    typedef struct packed {
        logic               mode;
        logic [BYTES_W-1:0] bytes;
        logic [IDX_W-1:0]   page;
        logic               typed;
        t_grant             want;
    } t_req_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               i_mode;
    logic [BYTES_W-1:0] i_request_bytes;
    logic [IDX_W-1:0]   i_start_page;
    logic               busy;
    logic               o_valid;
    logic               o_ok;
    logic [IDX_W-1:0]   o_page_index;
    logic [LEN_W-1:0]   o_page_count;

    logic [LEN_W-1:0]   map_shadow [PAGES];
    t_grant             pending_grants [$];
    logic [IDX_W-1:0]   live_heads [$];
    t_req_row           dir_rows [N_DIR];

    int  fail_count;
    int  idle_cycles;
    bit  idle_on;
    int  n_sent, n_grant, n_refuse, n_free, n_cleared;

    contiguous_page_allocator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_mode          (i_mode),
        .i_request_bytes (i_request_bytes),
        .i_start_page    (i_start_page),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_ok            (o_ok),
        .o_page_index    (o_page_index),
        .o_page_count    (o_page_count)
    );

    always #5 i_clk = ~i_clk;

    // First-fit search or free over the shadow map; updates the map and the list of live heads.
    function automatic t_grant predict_grant(logic mode, logic [BYTES_W-1:0] bytes,
                                             logic [IDX_W-1:0] page);
        t_grant g;
        int     need;
        int     len;
        int     base;
        int     k;
        bit     found;
        bit     clear;
        g = '0;
        if (mode == MODE_ALLOC) begin
            need  = (int'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
            found = 1'b0;
            base  = 0;
            if (need != 0 && need < MAX_RUN && need <= PAGES) begin
                for (int s = 0; s + need <= PAGES; s++) begin
                    if (!found) begin
                        clear = 1'b1;
                        for (k = 0; k < need; k++)
                            if (map_shadow[s + k] != '0) clear = 1'b0;
                        if (clear) begin
                            found = 1'b1;
                            base  = s;
                        end
                    end
                end
            end
            if (found) begin
                map_shadow[base] = LEN_W'(need);
                for (k = 1; k < need; k++)
                    map_shadow[base + k] = LEN_W'(1);
                g.ok  = 1'b1;
                g.idx = IDX_W'(base);
                g.cnt = LEN_W'(need);
                live_heads.push_back(IDX_W'(base));
                n_grant++;
            end else begin
                n_refuse++;
            end
        end else begin
            if (int'(page) < PAGES) begin
                len = map_shadow[page];
                if (len > PAGES - int'(page))
                    len = PAGES - int'(page);
                for (k = 0; k < len; k++)
                    map_shadow[int'(page) + k] = '0;
                g.ok  = 1'b1;
                g.cnt = LEN_W'(len);
                n_cleared += len;
                for (k = live_heads.size() - 1; k >= 0; k--)
                    if (live_heads[k] == page) live_heads.delete(k);
            end
            n_free++;
        end
        return g;
    endfunction

    // One request beat; start stays high across back-to-back beats.
    task automatic send_req(logic mode, logic [BYTES_W-1:0] bytes, logic [IDX_W-1:0] page,
                            logic typed, t_grant want, bit drain);
        int     gap;
        t_grant g;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0 || drain)
            start <= 1'b0;
        if (drain) begin
            do @(posedge i_clk); while (pending_grants.size() != 0);
        end
        repeat (gap) @(posedge i_clk);
        start           <= 1'b1;
        i_mode          <= mode;
        i_request_bytes <= bytes;
        i_start_page    <= page;
        do @(posedge i_clk); while (busy !== 1'b0);
        g = predict_grant(mode, bytes, page);
        pending_grants.push_back(typed ? want : g);
        n_sent++;
    endtask

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_grants.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: ok=%0b idx=%0d cnt=%0d",
                             o_ok, o_page_index, o_page_count);
            end else begin
                want = pending_grants.pop_front();
                if (o_ok !== want.ok || o_page_index !== want.idx
                        || o_page_count !== want.cnt) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("exp ok=%0b idx=%0d cnt=%0d / got ok=%0b idx=%0d cnt=%0d",
                                 want.ok, want.idx, want.cnt, o_ok, o_page_index, o_page_count);
                end
            end
        end
    end

    // Watchdog: cycles with neither a request beat nor a result beat.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("watchdog: no progress for %0d cycles", STALL_MAX);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stim
        logic [BYTES_W-1:0] bytes;
        logic [IDX_W-1:0]   page;
        logic               mode;
        int                 roll;
        int                 sub;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_mode          = MODE_ALLOC;
        i_request_bytes = '0;
        i_start_page    = '0;
        fail_count      = 0;
        idle_on         = 1'b1;
        n_sent = 0; n_grant = 0; n_refuse = 0; n_free = 0; n_cleared = 0;
        foreach (map_shadow[k]) map_shadow[k] = '0;

        // mode, bytes, page, typed, {ok, idx, cnt}
        dir_rows[0]  = {MODE_ALLOC, 20'd0,       6'd63, 1'b1, 1'b0, 6'd0, 8'd0};  // zero bytes
        dir_rows[1]  = {MODE_ALLOC, 20'hFFFFF,   6'd0,  1'b1, 1'b0, 6'd0, 8'd0};
        dir_rows[2]  = {MODE_ALLOC, 20'd65537,   6'd0,  1'b1, 1'b0, 6'd0, 8'd0};  // 65 pages
        dir_rows[3]  = {MODE_ALLOC, 20'd262144,  6'd0,  1'b1, 1'b0, 6'd0, 8'd0};  // 256 pages
        dir_rows[4]  = {MODE_ALLOC, 20'd65536,   6'd0,  1'b1, 1'b1, 6'd0, 8'd64}; // whole map
        dir_rows[5]  = {MODE_ALLOC, 20'd1,       6'd0,  1'b1, 1'b0, 6'd0, 8'd0};  // full
        dir_rows[6]  = {MODE_FREE,  20'd0,       6'd63, 1'b0, 15'd0}; // inside a run
        dir_rows[7]  = {MODE_ALLOC, 20'd1024,    6'd0,  1'b0, 15'd0};
        dir_rows[8]  = {MODE_FREE,  20'd0,       6'd0,  1'b0, 15'd0};
        dir_rows[9]  = {MODE_FREE,  20'd0,       6'd5,  1'b0, 15'd0}; // unused page
        dir_rows[10] = {MODE_ALLOC, 20'd1025,    6'd0,  1'b0, 15'd0};
        dir_rows[11] = {MODE_ALLOC, 20'd3072,    6'd0,  1'b0, 15'd0};
        dir_rows[12] = {MODE_FREE,  20'd0,       6'd0,  1'b0, 15'd0};
        dir_rows[13] = {MODE_ALLOC, 20'd2048,    6'd0,  1'b0, 15'd0};
        dir_rows[14] = {MODE_ALLOC, 20'd62464,   6'd0,  1'b0, 15'd0}; // would run off the end
        dir_rows[15] = {MODE_ALLOC, 20'd60416,   6'd0,  1'b0, 15'd0};
        dir_rows[16] = {MODE_FREE,  20'd0,       6'd60, 1'b0, 15'd0};
        dir_rows[17] = {MODE_FREE,  20'd0,       6'd5,  1'b0, 15'd0};
        dir_rows[18] = {MODE_FREE,  20'd0,       6'd2,  1'b0, 15'd0};
        dir_rows[19] = {MODE_FREE,  20'd0,       6'd0,  1'b0, 15'd0};
        dir_rows[20] = {MODE_ALLOC, 20'd1023,    6'd63, 1'b0, 15'd0};
        dir_rows[21] = {MODE_FREE,  20'hFFFFF,   6'd0,  1'b0, 15'd0};
        dir_rows[22] = {MODE_ALLOC, 20'd64512,   6'd0,  1'b0, 15'd0}; // 63 pages
        dir_rows[23] = {MODE_FREE,  20'd0,       6'd0,  1'b0, 15'd0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++)
            send_req(dir_rows[r].mode, dir_rows[r].bytes, dir_rows[r].page,
                     dir_rows[r].typed, dir_rows[r].want, 1'b0);

        for (int n = 0; n < N_RANDOM; n++) begin
            idle_on = ((n / 100) % 3) != 2;
            roll  = $urandom_range(0, 99);
            bytes = BYTES_W'($urandom);
            page  = IDX_W'($urandom);
            if (roll < 50) begin
                mode = MODE_ALLOC;
                sub  = $urandom_range(0, 9);
                if (sub < 6)
                    bytes = BYTES_W'($urandom_range(1, 4 * PAGE_BYTES));
                else if (sub < 8)
                    bytes = BYTES_W'($urandom_range(1, 16 * PAGE_BYTES));
                else if (sub == 8)
                    bytes = BYTES_W'($urandom_range(1, PAGES * PAGE_BYTES));
                else
                    bytes = BYTES_W'($urandom_range(1, 8) * PAGE_BYTES);
            end else if (roll < 88 && live_heads.size() != 0) begin
                mode = MODE_FREE;
                page = live_heads[$urandom_range(0, live_heads.size() - 1)];
            end else begin
                // noise: raw fields, stray frees, zero-byte requests
                mode = 1'($urandom);
                if (roll >= 96)
                    bytes = '0;
            end
            send_req(mode, bytes, page, 1'b0, '0, n == N_RANDOM / 2);
        end
        start <= 1'b0;

        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (pending_grants.size() != 0)
            fail_count++;

        $display("%0d requests: %0d allocations granted, %0d refused, %0d frees",
                 n_sent, n_grant, n_refuse, n_free);
        $display("%0d pages released by frees; %0d checks failed", n_cleared, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
